// ----- src/argument_intern_table_defines.svh -----
// Assertion macros used by the checker file of the argument intern table.
`ifndef ARGUMENT_INTERN_TABLE_DEFINES_SVH
`define ARGUMENT_INTERN_TABLE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define AIT_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("argument intern table check failed");

// next-cycle implication, disabled during reset
`define AIT_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("argument intern table check failed");

`endif

// ----- src/ait_pkg.sv -----
// Package with shared types and constants of the argument intern table.
`timescale 1ns / 1ps

package ait_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int ARG_TYPES_DEF   = 64;

  localparam int ACT_W     = 2;
  localparam int PRED_W    = 16;
  localparam int ARG_W     = 6;
  localparam int ID_W      = 10;
  localparam int INDEX_W   = 10;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 16;

  typedef enum logic [ACT_W-1:0] {
    ACT_QUERY        = 2'd0,
    ACT_QUERY_INSERT = 2'd1,
    ACT_INSERT_AT    = 2'd2
  } action_e;

endpackage

// ----- src/ait_cell.sv -----
// One cell of the intern table: holds a stored key and passes the lookup token on.
`timescale 1ns / 1ps

module ait_cell #(
  parameter int KEY_W    = 23,
  parameter int IDX_W    = 10,
  parameter int CNT_W    = 11,
  parameter int CELL_IDX = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [CNT_W-1:0] count_i,
  input  logic [KEY_W-1:0] key_i,
  input  logic             act_i,
  input  logic             hit_i,
  input  logic [IDX_W-1:0] idx_i,
  output logic             act_o,
  output logic             hit_o,
  output logic [IDX_W-1:0] idx_o
);

  logic [KEY_W-1:0] key_q;
  logic             act_q, act_d;
  logic             hit_q, hit_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             live;
  logic             match;

  assign live  = count_i > CNT_W'(CELL_IDX);
  assign match = act_i && live && !hit_i && (key_q == key_i);

  always_comb begin
    act_d = act_i;
    hit_d = hit_i | match;
    idx_d = match ? IDX_W'(CELL_IDX) : idx_i;
  end

  // append slot is the cell whose position equals the fill count
  always_ff @(posedge clk_i) begin
    if (wr_en_i && (count_i == CNT_W'(CELL_IDX))) begin
      key_q <= key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      hit_q <= 1'b0;
      idx_q <= '0;
    end else begin
      act_q <= act_d;
      hit_q <= hit_d;
      idx_q <= idx_d;
    end
  end

  assign act_o = act_q;
  assign hit_o = hit_q;
  assign idx_o = idx_q;

endmodule

// ----- src/argument_intern_table.sv -----
// Top level of the argument intern table: request control and the row of key cells.
`timescale 1ns / 1ps

// Intern table of signed keys (pred * ARG_TYPES + arg, negated for a left-side
// argument). Keys sit one per cell in a row of TABLE_DEPTH cells; a lookup token
// enters cell 0 and moves one cell per cycle. A query or query-insert request
// passes S_LAUNCH, the walk of the row and S_WAIT on its way to S_DONE; an
// insert-at-id request skips the walk and goes from S_IDLE straight to S_DONE.
// S_DONE loads the result register once the output is free and returns to
// S_IDLE with that load, where the next request is taken. One request is in
// flight at a time; a new request is taken while the previous result still
// waits on the output. No clearing pass: the fill count alone marks which cells
// hold keys.
module argument_intern_table #(
  parameter int TABLE_DEPTH = ait_pkg::TABLE_DEPTH_DEF,
  parameter int ARG_TYPES   = ait_pkg::ARG_TYPES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // tdata: pred[15:0], arg[21:16], on_right[22], id[32:23], zero[39:33]
  input  logic [ait_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  // tuser: action[1:0]
  input  logic [ait_pkg::ACT_W-1:0]          s_axis_tuser_i,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // tdata: index[9:0], found[10], accepted[11], table_full[12], zero[15:13]
  output logic [ait_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i
);

  import ait_pkg::*;

  localparam int ARG_BITS = ($clog2(ARG_TYPES) > ARG_W) ? $clog2(ARG_TYPES) : ARG_W;
  localparam int MAG_W    = PRED_W + ARG_BITS;
  localparam int KEY_W    = MAG_W + 1;
  localparam int IDX_W    = $clog2(TABLE_DEPTH);
  localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W    = (CNT_W > ID_W) ? CNT_W : ID_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LAUNCH,
    S_WAIT,
    S_DONE
  } state_e;

  state_e                 state_q;
  action_e                action_q;
  logic [ID_W-1:0]        id_q;
  logic [KEY_W-1:0]       key_q;
  logic                   hit_q;
  logic [IDX_W-1:0]       hit_idx_q;
  logic [CNT_W-1:0]       count_q;
  logic                   m_tvalid_q;
  logic [OUT_TDATA_W-1:0] m_tdata_q;

  logic [PRED_W-1:0]      in_pred;
  logic [ARG_W-1:0]       in_arg;
  logic                   in_on_right;
  logic [ID_W-1:0]        in_id;
  action_e                in_action;
  logic [MAG_W-1:0]       in_mag;
  logic [KEY_W-1:0]       key_d;
  logic                   in_take;

  logic                   out_free;
  logic                   fits;
  logic                   id_match;
  logic                   is_insert_at;
  logic                   do_append;
  logic                   r_full;
  logic                   r_found;
  logic                   r_acc;
  logic [INDEX_W-1:0]     r_index;
  logic [OUT_TDATA_W-1:0] r_tdata;
  logic                   wr_en;

  logic                   act_w [TABLE_DEPTH+1];
  logic                   hit_w [TABLE_DEPTH+1];
  logic [IDX_W-1:0]       idx_w [TABLE_DEPTH+1];

  assign in_pred     = s_axis_tdata_i[15:0];
  assign in_arg      = s_axis_tdata_i[21:16];
  assign in_on_right = s_axis_tdata_i[22];
  assign in_id       = s_axis_tdata_i[32:23];
  assign in_action   = action_e'(s_axis_tuser_i);

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_mag = MAG_W'(in_pred) * MAG_W'(ARG_TYPES) + MAG_W'(in_arg);
    key_d  = in_on_right ? {1'b0, in_mag} : (KEY_W'(0) - {1'b0, in_mag});
  end

  // result of the finished request
  always_comb begin
    out_free     = !m_tvalid_q || m_axis_tready_i;
    fits         = count_q < CNT_W'(TABLE_DEPTH);
    id_match     = CMP_W'(id_q) == CMP_W'(count_q);
    is_insert_at = (action_q == ACT_INSERT_AT);
    if (is_insert_at) begin
      do_append = id_match && fits;
      r_full    = id_match && !fits;
      r_found   = 1'b0;
    end else begin
      do_append = !hit_q && (action_q == ACT_QUERY_INSERT) && fits;
      r_full    = !hit_q && (action_q == ACT_QUERY_INSERT) && !fits;
      r_found   = hit_q;
    end
    r_acc = do_append || r_found;
    if (do_append) begin
      r_index = INDEX_W'(count_q);
    end else if (r_found) begin
      r_index = INDEX_W'(hit_idx_q);
    end else begin
      r_index = '0;
    end
    r_tdata = {3'b000, r_full, r_acc, r_found, r_index};
    wr_en   = (state_q == S_DONE) && out_free && do_append;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      action_q   <= ACT_QUERY;
      id_q       <= '0;
      key_q      <= '0;
      hit_q      <= 1'b0;
      hit_idx_q  <= '0;
      count_q    <= '0;
      m_tvalid_q <= 1'b0;
      m_tdata_q  <= '0;
    end else begin
      if ((state_q == S_DONE) && out_free) begin
        m_tvalid_q <= 1'b1;
        m_tdata_q  <= r_tdata;
      end else if (m_axis_tready_i) begin
        m_tvalid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_take) begin
            action_q <= in_action;
            id_q     <= in_id;
            key_q    <= key_d;
            hit_q    <= 1'b0;
            state_q  <= (in_action == ACT_INSERT_AT) ? S_DONE : S_LAUNCH;
          end
        end
        S_LAUNCH: begin
          state_q <= S_WAIT;
        end
        S_WAIT: begin
          if (act_w[TABLE_DEPTH]) begin
            hit_q     <= hit_w[TABLE_DEPTH];
            hit_idx_q <= idx_w[TABLE_DEPTH];
            state_q   <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            if (do_append) begin
              count_q <= count_q + CNT_W'(1);
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign act_w[0] = (state_q == S_LAUNCH);
  assign hit_w[0] = 1'b0;
  assign idx_w[0] = '0;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    ait_cell #(
      .KEY_W    (KEY_W),
      .IDX_W    (IDX_W),
      .CNT_W    (CNT_W),
      .CELL_IDX (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .wr_en_i (wr_en),
      .count_i (count_q),
      .key_i   (key_q),
      .act_i   (act_w[g]),
      .hit_i   (hit_w[g]),
      .idx_i   (idx_w[g]),
      .act_o   (act_w[g+1]),
      .hit_o   (hit_w[g+1]),
      .idx_o   (idx_w[g+1])
    );
  end

  assign m_axis_tvalid_o = m_tvalid_q;
  assign m_axis_tdata_o  = m_tdata_q;

endmodule

// ----- src/ait_checker.sv -----
// Port-level checks of the argument intern table and their binding to the top level.
`timescale 1ns / 1ps
`include "argument_intern_table_defines.svh"

module ait_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic [ait_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  input logic [ait_pkg::ACT_W-1:0]       s_axis_tuser_i,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic [ait_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i
);

  import ait_pkg::*;

  logic in_take;
  logic r_found;
  logic r_acc;
  logic r_full;

  assign in_take = s_axis_tvalid_i && s_axis_tready_o;
  assign r_found = m_axis_tdata_o[10];
  assign r_acc   = m_axis_tdata_o[11];
  assign r_full  = m_axis_tdata_o[12];

  // stalled result holds
  `AIT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i,
    m_axis_tvalid_o && $stable(m_axis_tdata_o))

  // one request in flight
  `AIT_ASSERT_NEXT(a_busy_after_take, clk_i, rst_ni, in_take, !s_axis_tready_o)

  `AIT_ASSERT_NOW(a_found_accepted, clk_i, rst_ni, m_axis_tvalid_o && r_found, r_acc)

  `AIT_ASSERT_NOW(a_full_refused, clk_i, rst_ni, m_axis_tvalid_o && r_full,
    !r_acc && (m_axis_tdata_o[9:0] == 10'd0))

  `AIT_ASSERT_NOW(a_reject_zero, clk_i, rst_ni, m_axis_tvalid_o && !r_acc,
    (m_axis_tdata_o[9:0] == 10'd0) && !r_found && (m_axis_tdata_o[15:13] == 3'd0))

endmodule

bind argument_intern_table ait_checker u_ait_checker (.*);

// ----- tb/tb.sv -----
// Self-checking stream testbench for the argument intern table.
`timescale 1ns / 1ps

module tb
  import ait_pkg::*;
;

  localparam int KEY_W       = PRED_W + ARG_W + 1;
  localparam int RANDOM_REQS = 550;
  localparam int STALL_LIMIT = 20 * (TABLE_DEPTH_DEF + 3);
  localparam int GEN_VIEW    = 0;
  localparam int DUT_VIEW    = 1;
  localparam logic [ACT_W-1:0] ACT_RESERVED = 2'd3;
  localparam int SEND_IDLE [3] = '{18, 65, 0};
  localparam int RECV_IDLE [3] = '{65, 18, 0};

  typedef logic [KEY_W-1:0] key_t;

  typedef struct {
    logic [ACT_W-1:0]  act;
    logic [PRED_W-1:0] pred;
    logic [ARG_W-1:0]  arg;
    logic              right;
    logic [ID_W-1:0]   id;
    bit                hold;
    int                mode;
  } req_t;

  typedef struct packed {
    logic               table_full;
    logic               accepted;
    logic               found;
    logic [INDEX_W-1:0] index;
  } res_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic [IN_TDATA_W-1:0]  s_axis_tdata_i  = '0;
  logic [ACT_W-1:0]       s_axis_tuser_i  = '0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;

  // key tables: one advanced while generating requests, one at acceptance
  key_t key_tab [2][TABLE_DEPTH_DEF];
  int   fill_cnt [2] = '{0, 0};

  req_t req_queue [$];
  res_t reply_queue [$];
  req_t cur_req;

  int idle_mode = 0;
  int n_acc = 0, n_rcv = 0;
  int n_hit = 0, n_app = 0, n_ref = 0, n_full = 0;
  int errors = 0;
  int stall_cnt = 0;

  argument_intern_table DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  function automatic res_t intern_predict(input int view, input req_t r);
    key_t k;
    res_t res;
    int   hit;
    k = key_t'(r.pred) * key_t'(ARG_TYPES_DEF) + key_t'(r.arg);
    if (!r.right) k = -k;
    res = '0;
    hit = -1;
    if (r.act == ACT_INSERT_AT) begin
      if (int'(r.id) == fill_cnt[view]) begin
        if (fill_cnt[view] >= TABLE_DEPTH_DEF) begin
          res.table_full = 1'b1;
        end else begin
          key_tab[view][fill_cnt[view]] = k;
          res.index = INDEX_W'(fill_cnt[view]);
          res.accepted = 1'b1;
          fill_cnt[view]++;
        end
      end
    end else begin
      for (int i = fill_cnt[view] - 1; i >= 0; i--)
        if (key_tab[view][i] == k) hit = i;
      if (hit >= 0) begin
        res.index = INDEX_W'(hit);
        res.found = 1'b1;
        res.accepted = 1'b1;
      end else if (r.act == ACT_QUERY_INSERT) begin
        if (fill_cnt[view] >= TABLE_DEPTH_DEF) begin
          res.table_full = 1'b1;
        end else begin
          key_tab[view][fill_cnt[view]] = k;
          res.index = INDEX_W'(fill_cnt[view]);
          res.accepted = 1'b1;
          fill_cnt[view]++;
        end
      end
    end
    return res;
  endfunction

  function automatic req_t mk(input int mode, input logic [ACT_W-1:0] act, input int pred,
                              input int arg, input bit right, input int id);
    req_t r;
    r = '{default: 0};
    r.mode = mode;
    r.act = act;
    r.pred = PRED_W'(pred);
    r.arg = ARG_W'(arg);
    r.right = right;
    r.id = ID_W'(id);
    return r;
  endfunction

  // mostly well-formed: half the keys are already stored, most ids are the next free slot
  function automatic req_t rand_req(input int mode);
    req_t r;
    key_t k;
    key_t mag;
    int   p;
    r = '{default: 0};
    r.mode = mode;
    p = $urandom_range(0, 99);
    if (p < 33) r.act = ACT_QUERY;
    else if (p < 66) r.act = ACT_QUERY_INSERT;
    else if (p < 94) r.act = ACT_INSERT_AT;
    else r.act = ACT_RESERVED;
    p = $urandom_range(0, 99);
    if (p < 50 && fill_cnt[GEN_VIEW] > 0) begin
      k = key_tab[GEN_VIEW][$urandom_range(0, fill_cnt[GEN_VIEW] - 1)];
      if (k == '0) r.right = 1'($urandom_range(0, 1));
      else r.right = !k[KEY_W-1];
      mag = k[KEY_W-1] ? -k : k;
      r.pred = PRED_W'(mag / ARG_TYPES_DEF);
      r.arg = ARG_W'(mag % ARG_TYPES_DEF);
    end else if (p < 53) begin
      r.right = 1'($urandom_range(0, 1));
    end else begin
      r.pred = (p < 70) ? PRED_W'($urandom_range(0, 7)) : PRED_W'($urandom_range(0, 65535));
      r.arg = ARG_W'($urandom_range(0, 63));
      r.right = 1'($urandom_range(0, 1));
    end
    if ($urandom_range(0, 99) < 80) r.id = ID_W'(fill_cnt[GEN_VIEW]);
    else r.id = ID_W'($urandom_range(0, 1023));
    return r;
  endfunction

  task automatic queue_req(input req_t r);
    req_queue = {req_queue, r};
    void'(intern_predict(GEN_VIEW, r));
  endtask

  task automatic queue_hold(input int mode);
    req_t r;
    r = '{default: 0};
    r.hold = 1'b1;
    r.mode = mode;
    req_queue = {req_queue, r};
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin : driver
    bit   fire;
    res_t want;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
      s_axis_tuser_i  <= '0;
    end else begin
      fire = s_axis_tvalid_i && s_axis_tready_o;
      if (fire) begin
        want = intern_predict(DUT_VIEW, cur_req);
        reply_queue = {reply_queue, want};
        n_acc <= n_acc + 1;
        if (want.found) n_hit++;
        else if (want.accepted) n_app++;
        else n_ref++;
        if (want.table_full) n_full++;
      end
      if (!s_axis_tvalid_i || fire) begin
        if (req_queue.size() > 0 && req_queue[0].hold && !fire && n_acc == n_rcv)
          void'(req_queue.pop_front());
        if (req_queue.size() > 0 && !req_queue[0].hold &&
            $urandom_range(0, 99) >= SEND_IDLE[req_queue[0].mode]) begin
          cur_req = req_queue.pop_front();
          idle_mode <= cur_req.mode;
          s_axis_tdata_i <= {7'b0, cur_req.id, cur_req.right, cur_req.arg, cur_req.pred};
          s_axis_tuser_i <= cur_req.act;
          s_axis_tvalid_i <= 1'b1;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // reply monitor
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    res_t got;
    res_t want;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(0, 99) >= RECV_IDLE[idle_mode]);
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        n_rcv <= n_rcv + 1;
        got = res_t'(m_axis_tdata_o[12:0]);
        if (reply_queue.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected reply: index %0d found %0d accepted %0d full %0d",
                     got.index, got.found, got.accepted, got.table_full);
        end else begin
          want = reply_queue.pop_front();
          if (got.index !== want.index || got.found !== want.found ||
              got.accepted !== want.accepted || got.table_full !== want.table_full) begin
            errors++;
            if (errors <= 10)
              $display("reply %0d mismatch (exp/act): index %0d/%0d found %0d/%0d %s%0d/%0d %s%0d/%0d",
                       n_rcv, want.index, got.index, want.found, got.found,
                       "accepted ", want.accepted, got.accepted,
                       "full ", want.table_full, got.table_full);
          end
        end
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        stall_cnt <= 0;
      end else if (stall_cnt >= STALL_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end else begin
        stall_cnt <= stall_cnt + 1;
      end
    end
  end

  initial begin : stimulus
    req_t r;
    int   mode;
    // directed: empty table, zero key on both sides, extreme fields, sign,
    // duplicates via insert-at-id, bad ids, reserved action code
    queue_req(mk(0, ACT_QUERY,        0,       0,  1, 0));
    queue_req(mk(0, ACT_QUERY_INSERT, 0,       0,  1, 0));
    queue_req(mk(0, ACT_QUERY,        0,       0,  0, 0));
    queue_req(mk(0, ACT_INSERT_AT,    0,       1,  1, 5));
    queue_req(mk(0, ACT_INSERT_AT,    'hFFFF,  63, 0, 1));
    queue_req(mk(0, ACT_QUERY_INSERT, 'hFFFF,  63, 0, 0));
    queue_req(mk(0, ACT_QUERY,        'hFFFF,  63, 1, 0));
    queue_req(mk(0, ACT_QUERY_INSERT, 'hFFFF,  63, 1, 'h3FF));
    queue_req(mk(0, ACT_INSERT_AT,    'hFFFF,  63, 1, 3));
    queue_req(mk(0, ACT_QUERY,        'hFFFF,  63, 1, 0));
    queue_req(mk(0, ACT_RESERVED,     'hFFFF,  63, 0, 0));
    queue_req(mk(0, ACT_RESERVED,     'h1234,  21, 1, 0));
    queue_req(mk(0, ACT_INSERT_AT,    'h8000,  32, 0, 'h3FF));
    queue_req(mk(0, ACT_INSERT_AT,    'h8000,  32, 0, 0));
    queue_req(mk(0, ACT_QUERY_INSERT, 1,       0,  1, 0));
    queue_req(mk(0, ACT_QUERY,        0,       63, 1, 0));
    queue_req(mk(0, ACT_INSERT_AT,    'h5555,  42, 0, 5));
    queue_req(mk(0, ACT_QUERY_INSERT, 'hAAAA,  21, 1, 'h2AA));
    queue_hold(0);

    for (int n = 0; n < RANDOM_REQS; n++) begin
      mode = (n < RANDOM_REQS / 3) ? 0 : (n < 2 * RANDOM_REQS / 3) ? 1 : 2;
      queue_req(rand_req(mode));
      if (n == RANDOM_REQS / 3 || n == 2 * RANDOM_REQS / 3) queue_hold(mode);
    end

    // closing probes on the filled part of the table
    queue_hold(2);
    for (int n = 0; n < 8; n++) begin
      r = rand_req(2);
      if (n < 4) r.act = ACT_QUERY_INSERT;
      else if (n < 7) r.act = ACT_QUERY;
      else r.act = ACT_RESERVED;
      queue_req(r);
    end
    queue_req(mk(2, ACT_QUERY_INSERT, 'hFFFF, 63, 0, 0));
    queue_req(mk(2, ACT_INSERT_AT,    'h0001, 1,  1, 0));
    queue_req(mk(2, ACT_INSERT_AT,    'h0001, 1,  1, 'h3FF));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(negedge clk_i);
    while (req_queue.size() > 0 || s_axis_tvalid_i || n_acc != n_rcv) @(negedge clk_i);
    repeat (TABLE_DEPTH_DEF + 8) @(negedge clk_i);
    if (reply_queue.size() != 0) begin
      $display("%0d expected replies never arrived", reply_queue.size());
      errors += reply_queue.size();
    end

    $display("Summary: %0d requests, %0d hits, %0d appends, %0d refusals (%0d on a full table)",
             n_acc, n_hit, n_app, n_ref, n_full);
    $display("Summary: table reached %0d of %0d entries, %0d errors",
             fill_cnt[DUT_VIEW], TABLE_DEPTH_DEF, errors);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
